FILE: rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off during reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition that must never hold
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/bmms_pkg.sv
`default_nettype none

package bmms_pkg;

  typedef logic signed [49:0] val_t;
  typedef logic signed [17:0] shape_t;
  typedef logic signed [31:0] q16_t;

  localparam int SINE_TABLE_BITS = 10;
  localparam logic [31:0] SINE_MASK = ~(32'hFFFF_FFFF >> SINE_TABLE_BITS);
  localparam logic [31:0] ONE_THIRD_TURN = 32'h5555_5555;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam val_t TURN_PER_RAD = 50'sd683565276;
  localparam logic [79:0] WIDE_LIM = 80'h3FFF_FFFF_FFFF;

  localparam logic [2:0] CFG_POLE_PAIRS = 3'd0;
  localparam logic [2:0] CFG_RESISTANCE = 3'd1;
  localparam logic [2:0] CFG_INV_IND    = 3'd2;
  localparam logic [2:0] CFG_EMF_K      = 3'd3;
  localparam logic [2:0] CFG_TORQUE_K   = 3'd4;
  localparam logic [2:0] CFG_FRICTION   = 3'd5;
  localparam logic [2:0] CFG_INV_INERT  = 3'd6;
  localparam logic [2:0] CFG_EMF_SHAPE  = 3'd7;

  function automatic q16_t sat32(val_t v);
    q16_t r;
    if (v > val_t'(32'sh7FFF_FFFF)) r = 32'sh7FFF_FFFF;
    else if (v < val_t'(-64'sd2147483648)) r = 32'sh8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [32:0] cordic_atan(logic [3:0] i);
    logic signed [32:0] r;
    unique case (i)
      4'd0:  r = 33'sd536870912;
      4'd1:  r = 33'sd316933406;
      4'd2:  r = 33'sd167458907;
      4'd3:  r = 33'sd85004756;
      4'd4:  r = 33'sd42667331;
      4'd5:  r = 33'sd21354465;
      4'd6:  r = 33'sd10679838;
      4'd7:  r = 33'sd5340245;
      4'd8:  r = 33'sd2670163;
      4'd9:  r = 33'sd1335087;
      4'd10: r = 33'sd667545;
      4'd11: r = 33'sd333772;
      4'd12: r = 33'sd166886;
      4'd13: r = 33'sd83443;
      4'd14: r = 33'sd41722;
      default: r = 33'sd20861;
    endcase
    return r;
  endfunction

  function automatic shape_t trap_shape(logic [31:0] u);
    logic signed [37:0] t;
    logic signed [37:0] d;
    shape_t r;
    t = $signed({6'd0, u}) * 38'sd12;
    if (u < 32'd357913942) begin
      d = t >>> 16;
      r = d[17:0];
    end else if (u < 32'd1789569707) begin
      r = 18'sd65536;
    end else if (u < 32'd2505397590) begin
      d = (38'sd25769803776 - t) >>> 16;
      r = d[17:0];
    end else if (u < 32'd3937053355) begin
      r = -18'sd65536;
    end else begin
      d = (t - 38'sd51539607552) >>> 16;
      r = d[17:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/bldc_motor_model_step_core.sv
// bldc motor emulator, one semi-implicit euler step per input beat.
// in_*: slave stream, one beat carries the phase voltages, load torque
//   and step length; in_tready is high only while the core is idle.
// out_*: master stream, one beat per step with the new currents, the
//   back-emf, the torque, the new speed and the electrical angle used.
// cfg_*: plain write port for the eight model registers; the user must see that
// they are written only while idle, the core does not enforce it. every product
// goes through one shared 48x24 multiplier, two passes per product plus an
// operand and a scale stage, 22 products per step. the sine shape runs a
// 16-iteration cordic per phase. one step at a time: no new input beat is
// taken until the result of the current step is loaded.
// the result sits in an output register, so the next input beat is taken
// the cycle after the result is loaded even if out_tready is low; a new
// step only finishes once the previous result has been taken.
// reset (rst_n low, synchronous) clears currents, speed and angle and
// restores the register defaults; no output beat is pending after reset.
`default_nettype none

module bldc_motor_model_step_core (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // volt_a, volt_b, volt_c, load_torque, step_time
  input  wire logic [159:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // amp_a, amp_b, amp_c, emf_a, emf_b, emf_c, motor_torque, speed_out, elec_angle
  output logic [287:0]      out_tdata,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [47:0]  cfg_wdata
);
  import bmms_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_THETA  = 4'd1;
  localparam logic [3:0] S_SHINIT = 4'd2;
  localparam logic [3:0] S_CORD   = 4'd3;
  localparam logic [3:0] S_CFIN   = 4'd4;
  localparam logic [3:0] S_MUL0   = 4'd5;
  localparam logic [3:0] S_MUL1   = 4'd6;
  localparam logic [3:0] S_MUL2   = 4'd7;
  localparam logic [3:0] S_POST   = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  localparam logic [3:0] OP_KW   = 4'd0;
  localparam logic [3:0] OP_FR   = 4'd1;
  localparam logic [3:0] OP_EMF  = 4'd2;
  localparam logic [3:0] OP_RI   = 4'd3;
  localparam logic [3:0] OP_DI   = 4'd4;
  localparam logic [3:0] OP_DIDT = 4'd5;
  localparam logic [3:0] OP_TS   = 4'd6;
  localparam logic [3:0] OP_TE   = 4'd7;
  localparam logic [3:0] OP_ACC  = 4'd8;
  localparam logic [3:0] OP_DV   = 4'd9;
  localparam logic [3:0] OP_RAD  = 4'd10;
  localparam logic [3:0] OP_ANG  = 4'd11;

  localparam logic [1:0] SH_16 = 2'd0;
  localparam logic [1:0] SH_24 = 2'd1;
  localparam logic [1:0] SH_32 = 2'd2;

  logic [3:0]  state_r;
  logic [3:0]  op_r;
  logic [1:0]  phase_r;

  logic [4:0]  pp_r;
  logic [47:0] res_r, inv_l_r, ke_r, kt_r, fric_r, inv_j_r;
  logic        shape_sel_r;

  q16_t        cur_r [3];
  q16_t        emf_r [3];
  q16_t        speed_r;
  logic [31:0] mech_r;
  q16_t        torque_r;
  logic [31:0] theta_r;

  q16_t        va_r, vb_r, vc_r, load_r;
  logic [31:0] dt_r;

  val_t        kw_r, fr_r, tmp_r, sum_r;
  shape_t      shape_r;

  logic signed [33:0] cx_r, cy_r;
  logic signed [32:0] cz_r;
  logic [3:0]  ci_r;
  logic [1:0]  quad_r;

  logic [47:0] ma_r, mb_r;
  logic        neg_r;
  logic [95:0] acc_r;

  logic        out_valid_r;
  logic [287:0] out_data_r;

  val_t        op_a, op_b, a_abs, b_abs, mres;
  logic [1:0]  sh_sel;
  logic        big_sel;
  logic [71:0] part;
  logic [79:0] shifted;
  logic [47:0] mag;
  logic [31:0] ang_u;
  q16_t        volt_sel;
  logic signed [33:0] cxs, cys;
  logic signed [34:0] cv, cvs;
  q16_t        te_sat;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    op_a    = '0;
    op_b    = '0;
    sh_sel  = SH_24;
    big_sel = 1'b0;
    unique case (op_r)
      OP_KW:   begin op_a = val_t'(speed_r); op_b = val_t'({2'b00, ke_r}); end
      OP_FR:   begin op_a = val_t'(speed_r); op_b = val_t'({2'b00, fric_r}); end
      OP_EMF:  begin op_a = kw_r; op_b = val_t'(shape_r); sh_sel = SH_16; end
      OP_RI:   begin op_a = val_t'({2'b00, res_r}); op_b = val_t'(cur_r[phase_r]); end
      OP_DI:   begin op_a = tmp_r; op_b = val_t'({2'b00, inv_l_r}); end
      OP_DIDT: begin op_a = tmp_r; op_b = val_t'({18'd0, dt_r}); sh_sel = SH_32; end
      OP_TS:   begin op_a = val_t'(cur_r[phase_r]); op_b = val_t'(shape_r); sh_sel = SH_16; end
      OP_TE:   begin op_a = sum_r; op_b = val_t'({2'b00, kt_r}); end
      OP_ACC:  begin op_a = tmp_r; op_b = val_t'({2'b00, inv_j_r}); end
      OP_DV:   begin op_a = tmp_r; op_b = val_t'({18'd0, dt_r}); sh_sel = SH_32; end
      OP_RAD:  begin
        op_a = val_t'(speed_r); op_b = val_t'({18'd0, dt_r}); sh_sel = SH_16; big_sel = 1'b1;
      end
      OP_ANG:  begin op_a = tmp_r; op_b = TURN_PER_RAD; sh_sel = SH_32; big_sel = 1'b1; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign a_abs = op_a[49] ? -op_a : op_a;
  assign b_abs = op_b[49] ? -op_b : op_b;

  assign part = ma_r * ((state_r == S_MUL1) ? mb_r[23:0] : mb_r[47:24]);

  always_comb begin
    unique case (sh_sel)
      SH_16:   shifted = acc_r[95:16];
      SH_24:   shifted = {8'd0, acc_r[95:24]};
      default: shifted = {16'd0, acc_r[95:32]};
    endcase
    if (!big_sel && (shifted > WIDE_LIM)) mag = WIDE_LIM[47:0];
    else mag = shifted[47:0];
    mres = neg_r ? -val_t'({2'b00, mag}) : val_t'({2'b00, mag});
  end

  always_comb begin
    unique case (phase_r)
      2'd0:    begin ang_u = theta_r;                  volt_sel = va_r; end
      2'd1:    begin ang_u = theta_r - ONE_THIRD_TURN; volt_sel = vb_r; end
      default: begin ang_u = theta_r + ONE_THIRD_TURN; volt_sel = vc_r; end
    endcase
  end

  assign cxs = cx_r >>> ci_r;
  assign cys = cy_r >>> ci_r;

  always_comb begin
    unique case (quad_r)
      2'd0:    cv = 35'(cy_r);
      2'd1:    cv = 35'(cx_r);
      2'd2:    cv = -35'(cy_r);
      default: cv = -35'(cx_r);
    endcase
    cvs = cv >>> 14;
    if (cvs > 35'sd65536) cvs = 35'sd65536;
    else if (cvs < -35'sd65536) cvs = -35'sd65536;
  end

  assign te_sat = sat32(mres);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_KW;
      phase_r     <= 2'd0;
      pp_r        <= 5'd1;
      res_r       <= 48'd16777216;
      inv_l_r     <= 48'd16777216;
      ke_r        <= '0;
      kt_r        <= '0;
      fric_r      <= '0;
      inv_j_r     <= 48'd16777216;
      shape_sel_r <= 1'b0;
      cur_r[0]    <= '0;
      cur_r[1]    <= '0;
      cur_r[2]    <= '0;
      speed_r     <= '0;
      mech_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_POLE_PAIRS: pp_r        <= cfg_wdata[4:0];
          CFG_RESISTANCE: res_r       <= cfg_wdata;
          CFG_INV_IND:    inv_l_r     <= cfg_wdata;
          CFG_EMF_K:      ke_r        <= cfg_wdata;
          CFG_TORQUE_K:   kt_r        <= cfg_wdata;
          CFG_FRICTION:   fric_r      <= cfg_wdata;
          CFG_INV_INERT:  inv_j_r     <= cfg_wdata;
          CFG_EMF_SHAPE:  shape_sel_r <= cfg_wdata[0];
          default:        pp_r        <= pp_r;
        endcase
      end

      if (out_valid_r && out_tready && (state_r != S_DONE)) out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            va_r    <= in_tdata[31:0];
            vb_r    <= in_tdata[63:32];
            vc_r    <= in_tdata[95:64];
            load_r  <= in_tdata[127:96];
            dt_r    <= in_tdata[159:128];
            state_r <= S_THETA;
          end
        end
        S_THETA: begin
          theta_r <= 32'(pp_r * mech_r);
          sum_r   <= '0;
          phase_r <= 2'd0;
          op_r    <= OP_KW;
          state_r <= S_MUL0;
        end
        S_SHINIT: begin
          if (shape_sel_r) begin
            shape_r <= -trap_shape(ang_u);
            op_r    <= OP_EMF;
            state_r <= S_MUL0;
          end else begin
            cz_r    <= {3'd0, ang_u[29:0] & SINE_MASK[29:0]};
            quad_r  <= ang_u[31:30] & SINE_MASK[31:30];
            cx_r    <= CORDIC_GAIN;
            cy_r    <= '0;
            ci_r    <= '0;
            state_r <= S_CORD;
          end
        end
        S_CORD: begin
          if (cz_r >= 0) begin
            cx_r <= cx_r - cys;
            cy_r <= cy_r + cxs;
            cz_r <= cz_r - cordic_atan(ci_r);
          end else begin
            cx_r <= cx_r + cys;
            cy_r <= cy_r - cxs;
            cz_r <= cz_r + cordic_atan(ci_r);
          end
          ci_r <= ci_r + 4'd1;
          if (ci_r == 4'd15) state_r <= S_CFIN;
        end
        S_CFIN: begin
          shape_r <= -shape_t'(cvs);
          op_r    <= OP_EMF;
          state_r <= S_MUL0;
        end
        S_MUL0: begin
          ma_r    <= a_abs[47:0];
          mb_r    <= b_abs[47:0];
          neg_r   <= op_a[49] ^ op_b[49];
          state_r <= S_MUL1;
        end
        S_MUL1: begin
          acc_r   <= {24'd0, part};
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          acc_r   <= acc_r + {part, 24'd0};
          state_r <= S_POST;
        end
        S_POST: begin
          state_r <= S_MUL0;
          unique case (op_r)
            OP_KW: begin kw_r <= mres; op_r <= OP_FR; end
            OP_FR: begin fr_r <= mres; state_r <= S_SHINIT; end
            OP_EMF: begin emf_r[phase_r] <= sat32(mres); op_r <= OP_RI; end
            OP_RI: begin
              tmp_r <= val_t'(volt_sel) - mres - val_t'(emf_r[phase_r]);
              op_r  <= OP_DI;
            end
            OP_DI: begin tmp_r <= mres; op_r <= OP_DIDT; end
            OP_DIDT: begin
              cur_r[phase_r] <= sat32(val_t'(cur_r[phase_r]) + mres);
              op_r <= OP_TS;
            end
            OP_TS: begin
              sum_r <= sum_r + mres;
              if (phase_r == 2'd2) begin
                op_r <= OP_TE;
              end else begin
                phase_r <= phase_r + 2'd1;
                state_r <= S_SHINIT;
              end
            end
            OP_TE: begin
              torque_r <= te_sat;
              tmp_r    <= val_t'(te_sat) - val_t'(load_r) - fr_r;
              op_r     <= OP_ACC;
            end
            OP_ACC: begin tmp_r <= mres; op_r <= OP_DV; end
            OP_DV: begin speed_r <= sat32(val_t'(speed_r) + mres); op_r <= OP_RAD; end
            OP_RAD: begin tmp_r <= mres; op_r <= OP_ANG; end
            default: begin
              mech_r  <= mech_r + mres[31:0];
              state_r <= S_DONE;
            end
          endcase
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_data_r  <= {theta_r, speed_r, torque_r, emf_r[2], emf_r[1], emf_r[0],
                            cur_r[2], cur_r[1], cur_r[0]};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`include "assert_macros.svh"

  `ASSERT_CLK(a_accept_starts, (in_tvalid && in_tready) |=> (state_r == S_THETA), "beat did not start a step")
  `ASSERT_CLK(a_done_loads, (state_r == S_DONE && (!out_valid_r || out_tready)) |=> out_valid_r, "result not loaded")
  `ASSERT_NEVER(a_phase_range, phase_r == 2'd3, "phase index out of range")

endmodule

`default_nettype wire
